// ===== design/cswd_pkg.sv =====
// Shared types and constants for the byte stack with duplicate removal.
// No dependencies; every other design file imports this package.
package cswd_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DATA_W          = 8;
  localparam int COUNT_W         = 5;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_DEDUPE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_DD_IW,
    S_DD_JW,
    S_DD_KEEP
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    status_t             status;
  } rsp_t;

endpackage

// ===== design/cswd_mem.sv =====
// Stack storage: one write port, one read port with registered read data.
// Depends on cswd_pkg for the data width.
module cswd_mem
  import cswd_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cswd_seq.sv =====
// Sequencer for push, pop, peek and the duplicate-removal walk, with the
// shared byte comparator. Depends on cswd_pkg; drives the cswd_mem ports.
module cswd_seq
  import cswd_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_action,
  input  logic [DATA_W-1:0] in_push_value,
  output logic              busy,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [DATA_W-1:0] mem_rdata,
  output rsp_t              rsp
);

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     kept_r, kept_nxt;
  logic [DATA_W-1:0] v_r, v_nxt;

  logic [CW-1:0] top_idx;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;
  logic [CW-1:0] kept_inc;
  logic          last_i;
  logic          match;

  assign top_idx  = count_r - 1'b1;
  assign i_inc    = i_r + 1'b1;
  assign j_inc    = j_r + 1'b1;
  assign kept_inc = kept_r + 1'b1;
  assign last_i   = (i_inc == count_r);
  assign match    = (mem_rdata == v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    kept_r <= kept_nxt;
    v_r    <= v_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    kept_nxt   = kept_r;
    v_nxt      = v_r;
    mem_we     = 1'b0;
    mem_waddr  = count_r[AW-1:0];
    mem_wdata  = in_push_value;
    mem_raddr  = '0;
    rsp        = '0;
    rsp.status = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = action_t'(in_action);
          case (action_t'(in_action))
            ACT_PUSH: begin
              rsp.valid = 1'b1;
              if (count_r == CW'(STACK_DEPTH)) begin
                rsp.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (count_r == '0) begin
                rsp.valid  = 1'b1;
                rsp.status = ST_EMPTY;
              end else begin
                mem_raddr = top_idx[AW-1:0];
                state_nxt = S_RD_WAIT;
              end
            end
            ACT_DEDUPE: begin
              if (count_r == '0) begin
                rsp.valid = 1'b1;
              end else begin
                // read the bottom entry to start the walk
                i_nxt     = '0;
                kept_nxt  = '0;
                state_nxt = S_DD_IW;
              end
            end
            default: ;
          endcase
        end
      end

      S_RD_WAIT: begin
        rsp.valid = 1'b1;
        rsp.data  = mem_rdata;
        if (act_r == ACT_POP) begin
          count_nxt = top_idx;
        end
        state_nxt = S_IDLE;
      end

      S_DD_IW: begin
        v_nxt = mem_rdata;
        if (kept_r == '0) begin
          state_nxt = S_DD_KEEP;
        end else begin
          j_nxt     = '0;
          state_nxt = S_DD_JW;
        end
      end

      S_DD_JW: begin
        if (match) begin
          // drop: value already held deeper
          if (last_i) begin
            count_nxt = kept_r;
            rsp.valid = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_inc;
            mem_raddr = i_inc[AW-1:0];
            state_nxt = S_DD_IW;
          end
        end else if (j_inc == kept_r) begin
          state_nxt = S_DD_KEEP;
        end else begin
          j_nxt     = j_inc;
          mem_raddr = j_inc[AW-1:0];
        end
      end

      S_DD_KEEP: begin
        mem_we    = 1'b1;
        mem_waddr = kept_r[AW-1:0];
        mem_wdata = v_r;
        kept_nxt  = kept_inc;
        if (last_i) begin
          count_nxt = kept_inc;
          rsp.valid = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_inc;
          mem_raddr = i_inc[AW-1:0];
          state_nxt = S_DD_IW;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rsp.count = COUNT_W'(count_nxt);
    rsp.empty = (count_nxt == '0);
  end

  assign busy = (state_r != S_IDLE);

  // keep the compare-path read address on the first compare of each entry
  // (index 0 is the mem_raddr default)

endmodule

// ===== design/char_stack_with_dedupe.sv =====
// Byte stack with duplicate removal. Push: strobe in the cycle after start.
// Pop and peek: registered read, S_RD_WAIT, then the strobe register; on an empty
// stack the strobe comes in the cycle after start. Dedupe: one byte compare a cycle.
// busy stays high until the result is formed; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the stack; store contents are not cleared.
module char_stack_with_dedupe
  import cswd_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [DATA_W-1:0]  in_push_value,
  output logic               out_strobe,
  output logic [DATA_W-1:0]  out_data_out,
  output logic [COUNT_W-1:0] out_entry_count,
  output logic               out_is_empty,
  output logic [1:0]         out_status
);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  rsp_t              rsp;

  logic               strobe_r;
  logic [DATA_W-1:0]  data_r;
  logic [COUNT_W-1:0] count_r;
  logic               empty_r;
  status_t            status_r;

  cswd_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_action     (in_action),
    .in_push_value (in_push_value),
    .busy          (busy),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .rsp           (rsp)
  );

  cswd_mem #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= rsp.valid;
    end
  end

  // hold the last result payload until the next one
  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      data_r   <= rsp.data;
      count_r  <= rsp.count;
      empty_r  <= rsp.empty;
      status_r <= rsp.status;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_data_out    = data_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = empty_r;
  assign out_status      = status_r;

endmodule

// ===== design/cswd_checker.sv =====
// Port-level checks for char_stack_with_dedupe, attached by bind below.
// Depends on cswd_pkg for action and status codes.
module cswd_checker
  import cswd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_action,
  input logic               out_strobe,
  input logic [DATA_W-1:0]  out_data_out,
  input logic [COUNT_W-1:0] out_entry_count,
  input logic               out_is_empty,
  input logic [1:0]         out_status
);

  // a push request gives a result strobe in the next cycle
  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == ACT_PUSH |=> out_strobe)
    else $error("push request gave no result in the next cycle");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_empty |-> out_entry_count == '0)
    else $error("empty flag with nonzero count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_EMPTY |-> out_data_out == '0 && out_is_empty)
    else $error("empty status with data or entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_FULL |-> out_data_out == '0 && !out_is_empty)
    else $error("full status with data or empty stack");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status == ST_OK || out_status == ST_EMPTY ||
                   out_status == ST_FULL)
    else $error("undefined status code");

endmodule

bind char_stack_with_dedupe cswd_checker u_cswd_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for char_stack_with_dedupe: directed and randomized requests.
// Depends on cswd_pkg and the char_stack_with_dedupe RTL; predicts each result internally.
module tb;
  import cswd_pkg::*;

  localparam int DEPTH       = DEF_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 1_000_000;
  // drain margin covers the longest dedupe, the one on a full stack
  localparam int DRAIN_CYCLES = DEPTH * (DEPTH + 3) / 2 + 8;

  typedef struct {
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               empty;
    status_t            status;
  } stack_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         in_action = 2'd0;
  logic [DATA_W-1:0]  in_push_value = '0;
  logic               busy;
  logic               out_strobe;
  logic [DATA_W-1:0]  out_data_out;
  logic [COUNT_W-1:0] out_entry_count;
  logic               out_is_empty;
  logic [1:0]         out_status;

  // predicted stack contents, entry 0 at the bottom
  logic [DATA_W-1:0] model_bytes [DEPTH];
  int                model_fill = 0;
  stack_result_t     pending_results [$];
  int                error_count = 0;
  int                cycle_count = 0;

  char_stack_with_dedupe #(.STACK_DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_push_value   (in_push_value),
    .out_strobe      (out_strobe),
    .out_data_out    (out_data_out),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("char_stack_with_dedupe verification failed");
      $finish;
    end
  end

  // Keep the deepest copy of each value, preserving bottom-to-top order.
  function automatic void squeeze_repeats();
    int          kept;
    bit          seen;
    logic [7:0]  v;
    kept = 0;
    for (int i = 0; i < model_fill; i++) begin
      v = model_bytes[i];
      seen = 1'b0;
      for (int j = 0; j < kept; j++) begin
        if (model_bytes[j] == v) seen = 1'b1;
      end
      if (!seen) begin
        model_bytes[kept] = v;
        kept++;
      end
    end
    model_fill = kept;
  endfunction

  function automatic void apply_stack_action(input action_t act, input logic [7:0] val);
    stack_result_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (model_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_bytes[model_fill] = val;
          model_fill++;
        end
      end
      ACT_POP: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          model_fill--;
          r.data = model_bytes[model_fill];
        end
      end
      ACT_PEEK: begin
        if (model_fill == 0) r.status = ST_EMPTY;
        else r.data = model_bytes[model_fill - 1];
      end
      default: squeeze_repeats();
    endcase
    r.count = COUNT_W'(model_fill);
    r.empty = (model_fill == 0);
    pending_results.push_back(r);
  endfunction

  // Result strobes cannot be held off, so check every one at the edge that takes it.
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.data) begin
          $error("out_data_out mismatch: expected %0h, got %0h", want.data, out_data_out);
          error_count++;
        end
        if (out_entry_count !== want.count) begin
          $error("out_entry_count mismatch: expected %0d, got %0d",
                 want.count, out_entry_count);
          error_count++;
        end
        if (out_is_empty !== want.empty) begin
          $error("out_is_empty mismatch: expected %0b, got %0b", want.empty, out_is_empty);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status mismatch: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Send one request; leave start high so back-to-back requests need no extra step.
  task automatic issue_request(input action_t act, input logic [7:0] val,
                               input int idle_pct);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_action     <= act;
    in_push_value <= val;
    do @(posedge clk); while (busy);
    apply_stack_action(act, val);
  endtask

  task automatic test_empty_stack();
    issue_request(ACT_POP, 8'hFF, 0);
    issue_request(ACT_PEEK, 8'h00, 0);
    issue_request(ACT_DEDUPE, 8'hA5, 0);
  endtask

  task automatic test_fill_to_full();
    logic [7:0] fill_vals [16] = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h7F, 8'h55,
                                   8'hAA, 8'h55, 8'h00, 8'h12, 8'h34, 8'h12, 8'hFE, 8'h01};
    for (int i = 0; i < DEPTH; i++) issue_request(ACT_PUSH, fill_vals[i % 16], 0);
    // stack is full: this push must be dropped
    issue_request(ACT_PUSH, 8'hC3, 0);
  endtask

  task automatic test_dedupe();
    issue_request(ACT_DEDUPE, 8'h00, 0);
    // nothing left to remove on the second pass
    issue_request(ACT_DEDUPE, 8'hFF, 0);
    issue_request(ACT_PEEK, 8'h00, 0);
    issue_request(ACT_POP, 8'h00, 0);
    issue_request(ACT_PEEK, 8'h00, 0);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int         mood;
    int         left;
    int         pick;
    action_t    act;
    logic [7:0] val;
    logic [7:0] pool [4];
    mood = 0;
    left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (left == 0) begin
        // pick a traffic mood and a small value pool for this burst
        mood = $urandom_range(0, 3);
        left = $urandom_range(4, 24);
        for (int p = 0; p < 4; p++) pool[p] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) pool[0] = 8'h00;
        if ($urandom_range(0, 3) == 0) pool[1] = 8'hFF;
      end
      left--;
      pick = $urandom_range(0, 99);
      case (mood)
        0: begin
          if (pick < 75) act = ACT_PUSH;
          else if (pick < 85) act = ACT_PEEK;
          else if (pick < 93) act = ACT_DEDUPE;
          else act = ACT_POP;
        end
        1: begin
          if (pick < 60) act = ACT_POP;
          else if (pick < 78) act = ACT_PEEK;
          else if (pick < 88) act = ACT_DEDUPE;
          else act = ACT_PUSH;
        end
        2: begin
          if (pick < 60) act = ACT_PUSH;
          else if (pick < 78) act = ACT_DEDUPE;
          else if (pick < 90) act = ACT_POP;
          else act = ACT_PEEK;
        end
        default: act = action_t'(2'($urandom_range(0, 3)));
      endcase
      if (mood == 2 || $urandom_range(0, 1) == 1) val = pool[$urandom_range(0, 3)];
      else val = 8'($urandom_range(0, 255));
      issue_request(act, val, idle_pct);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_fill_to_full();
    test_dedupe();
    test_random_traffic(320, 0);
    test_random_traffic(320, 72);
    test_random_traffic(320, 32);
    test_random_traffic(320, 0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("char_stack_with_dedupe verification clean");
    end else begin
      $display("char_stack_with_dedupe verification failed");
    end
    $finish;
  end

endmodule
